/* src/pep_pkg.sv */
// Shared types and constants of the pointer event generator.
package pep_pkg;

  localparam int CoordW = 16;
  localparam int DeltaW = 18;
  localparam int EdgeW  = 13;
  localparam int CodeW  = 8;
  localparam int CountW = 3;

  localparam logic [CountW-1:0] REPEAT_MAX      = 3'd4;
  localparam logic [CountW:0]   MAX_WHEEL_STEPS = 4'd5;

  // n / 10 == (n * 0xCCCD) >> 19 for every 16-bit n
  localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
  localparam int          DIV10_SHIFT = 19;

  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [CodeW-1:0] CODE_CLICK    = 8'd1;
  localparam logic [CodeW-1:0] CODE_REPEAT   = 8'd2;
  localparam logic [CodeW-1:0] CODE_DOUBLE   = 8'd3;
  localparam logic [CodeW-1:0] CODE_WHEEL_DN = 8'd4;
  localparam logic [CodeW-1:0] CODE_WHEEL_UP = 8'd5;
  localparam logic [CodeW-1:0] CODE_PRESS    = 8'd6;
  localparam logic [CodeW-1:0] CODE_RELEASE  = 8'd7;
  localparam logic [CodeW-1:0] CODE_RIGHT    = 8'd8;

  typedef enum logic [2:0] {
    KIND_REL_X = 3'd0,
    KIND_REL_Y = 3'd1,
    KIND_WHEEL = 3'd2,
    KIND_LEFT  = 3'd3,
    KIND_RIGHT = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_CLICK,
    ACT_DOUBLE,
    ACT_WHEEL_DN,
    ACT_WHEEL_UP,
    ACT_PRESS,
    ACT_RELEASE,
    ACT_RIGHT
  } act_t;

  typedef struct packed {
    logic signed [DeltaW-1:0] dx;
    logic signed [DeltaW-1:0] dy;
    logic                     nz_x;
    logic                     nz_y;
    act_t                     act;
    logic [CountW-1:0]        total;
  } batch_t;

endpackage

/* src/pointer_event_generator.sv */
// Top level of the pointer event generator.
// Each request carries a pointer position and an optional gesture code and
// yields zero to seven relative mouse events: an X delta and a Y delta when
// nonzero (each with a tenth of any off-screen overshoot added), then the
// events of the gesture. A request enters the front stage when it is free,
// waits there for the event register, where its events leave at one per
// cycle while out_stall is low; one with none passes through without using
// the event stage. The front stage forms the raw deltas and overshoot, the
// second stage scales the overshoot by one multiply, and the next request
// waits in the front stage while the current events drain. The user must
// write screen size through the register port while no request is in
// flight; the block does not enforce this.
module pointer_event_generator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic                               wr_index,
  input  logic [pep_pkg::EdgeW-1:0]          wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [pep_pkg::CoordW-1:0]  pos_x,
  input  logic signed [pep_pkg::CoordW-1:0]  pos_y,
  input  logic                               has_code,
  input  logic [pep_pkg::CodeW-1:0]          gesture_code,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [2:0]                         event_kind,
  output logic signed [pep_pkg::DeltaW-1:0]  event_value,
  output logic                               last_event
);
  import pep_pkg::*;

  function automatic logic signed [DeltaW-1:0] axis_diff(
    input logic signed [CoordW-1:0] pos,
    input logic signed [CoordW-1:0] prev
  );
    return {{2{pos[CoordW-1]}}, pos} - {{2{prev[CoordW-1]}}, prev};
  endfunction

  function automatic logic [CoordW-1:0] overshoot(
    input logic signed [CoordW-1:0] pos,
    input logic [EdgeW-1:0]         edge_px
  );
    logic signed [CoordW:0] neg;
    logic signed [CoordW:0] over;
    neg  = -{pos[CoordW-1], pos};
    over = {pos[CoordW-1], pos} - $signed({4'b0000, edge_px});
    if (pos[CoordW-1]) return neg[CoordW-1:0];
    else if (over > 17'sd0) return over[CoordW-1:0];
    else return '0;
  endfunction

  function automatic logic signed [DeltaW-1:0] apply_over(
    input logic signed [DeltaW-1:0] diff,
    input logic [CoordW-1:0]        mag,
    input logic                     sub
  );
    logic [31:0]              prod;
    logic signed [DeltaW-1:0] q;
    prod = {16'b0, mag} * {16'b0, DIV10_MUL};
    q    = $signed({5'b0, prod[31:DIV10_SHIFT]});
    return sub ? diff - q : diff + q;
  endfunction

  logic [EdgeW-1:0]         screen_width;
  logic [EdgeW-1:0]         screen_height;
  logic signed [CoordW-1:0] prev_x;
  logic signed [CoordW-1:0] prev_y;
  logic [CodeW-1:0]         prev_code;
  logic [CountW-1:0]        repeat_count;

  logic                     valid1;
  logic signed [DeltaW-1:0] s1_diff_x;
  logic signed [DeltaW-1:0] s1_diff_y;
  logic [CoordW-1:0]        s1_mag_x;
  logic [CoordW-1:0]        s1_mag_y;
  logic                     s1_sub_x;
  logic                     s1_sub_y;
  act_t                     s1_act;
  logic [CountW-1:0]        s1_gcount;

  logic                     valid2;
  batch_t                   batch;
  logic [CountW-1:0]        idx;

  logic [CodeW-1:0]         act_code;
  logic [CodeW-1:0]         prev_code_next;
  logic [CountW-1:0]        repeat_count_next;
  logic [CountW:0]          steps_w;
  logic [CountW-1:0]        steps;
  act_t                     act_next;
  logic [CountW-1:0]        gcount_next;
  batch_t                   batch_next;

  kind_t                    sel_kind;
  logic                     sel_last;
  logic                     s2_free;
  logic                     adv1;
  logic                     accept_in;

  always_comb begin
    act_code          = gesture_code;
    prev_code_next    = prev_code;
    repeat_count_next = repeat_count;
    if (has_code) begin
      if (gesture_code == CODE_REPEAT) begin
        act_code = prev_code;
        if (repeat_count < REPEAT_MAX) repeat_count_next = repeat_count + 3'd1;
      end else begin
        prev_code_next    = gesture_code;
        repeat_count_next = '0;
      end
    end
    steps_w = {1'b0, repeat_count_next} + 4'd1;
    steps   = (steps_w > MAX_WHEEL_STEPS) ? MAX_WHEEL_STEPS[CountW-1:0]
                                          : steps_w[CountW-1:0];
    act_next    = ACT_NONE;
    gcount_next = '0;
    if (has_code) begin
      case (act_code)
        CODE_CLICK:    begin act_next = ACT_CLICK;    gcount_next = 3'd2;  end
        CODE_DOUBLE:   begin act_next = ACT_DOUBLE;   gcount_next = 3'd4;  end
        CODE_WHEEL_DN: begin act_next = ACT_WHEEL_DN; gcount_next = steps; end
        CODE_WHEEL_UP: begin act_next = ACT_WHEEL_UP; gcount_next = steps; end
        CODE_PRESS:    begin act_next = ACT_PRESS;    gcount_next = 3'd1;  end
        CODE_RELEASE:  begin act_next = ACT_RELEASE;  gcount_next = 3'd1;  end
        CODE_RIGHT:    begin act_next = ACT_RIGHT;    gcount_next = 3'd2;  end
        default:       begin act_next = ACT_NONE;     gcount_next = '0;    end
      endcase
    end
  end

  always_comb begin
    batch_next.dx    = apply_over(s1_diff_x, s1_mag_x, s1_sub_x);
    batch_next.dy    = apply_over(s1_diff_y, s1_mag_y, s1_sub_y);
    batch_next.nz_x  = (batch_next.dx != '0);
    batch_next.nz_y  = (batch_next.dy != '0);
    batch_next.act   = s1_act;
    batch_next.total = {2'b0, batch_next.nz_x} + {2'b0, batch_next.nz_y} + s1_gcount;
  end

  pep_event_sel u_sel (
    .batch (batch),
    .idx   (idx),
    .kind  (sel_kind),
    .value (event_value),
    .last  (sel_last)
  );

  assign event_kind = sel_kind;
  assign last_event = sel_last;
  assign out_valid  = valid2;
  assign s2_free    = !valid2 || (!out_stall && sel_last);
  assign adv1       = valid1 && s2_free;
  assign in_stall   = valid1 && !s2_free;
  assign accept_in  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 13'd1920;
      screen_height <= 13'd1080;
      prev_x        <= '0;
      prev_y        <= '0;
      prev_code     <= '0;
      repeat_count  <= '0;
      valid1        <= 1'b0;
      valid2        <= 1'b0;
      idx           <= '0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_SCREEN_WIDTH:  screen_width  <= wr_data;
          REG_SCREEN_HEIGHT: screen_height <= wr_data;
          default: ;
        endcase
      end

      if (accept_in) begin
        prev_x       <= pos_x;
        prev_y       <= pos_y;
        prev_code    <= prev_code_next;
        repeat_count <= repeat_count_next;
        valid1       <= 1'b1;
      end else if (adv1) begin
        valid1 <= 1'b0;
      end

      if (adv1) begin
        valid2 <= (batch_next.total != '0);
        idx    <= '0;
      end else if (valid2 && !out_stall) begin
        if (sel_last) valid2 <= 1'b0;
        else idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      s1_diff_x <= axis_diff(pos_x, prev_x);
      s1_diff_y <= axis_diff(pos_y, prev_y);
      s1_mag_x  <= overshoot(pos_x, screen_width);
      s1_mag_y  <= overshoot(pos_y, screen_height);
      s1_sub_x  <= pos_x[CoordW-1];
      s1_sub_y  <= pos_y[CoordW-1];
      s1_act    <= act_next;
      s1_gcount <= gcount_next;
    end
    if (adv1) batch <= batch_next;
  end

endmodule

/* src/pep_event_sel.sv */
// Picks the event at a given position of one request's event list.
module pep_event_sel (
  input  pep_pkg::batch_t                    batch,
  input  logic [pep_pkg::CountW-1:0]         idx,
  output pep_pkg::kind_t                     kind,
  output logic signed [pep_pkg::DeltaW-1:0]  value,
  output logic                               last
);
  import pep_pkg::*;

  logic [1:0]        offset;
  logic [CountW-1:0] k;

  always_comb begin
    offset = {1'b0, batch.nz_x} + {1'b0, batch.nz_y};
    k      = idx - {1'b0, offset};
    last   = (idx == batch.total - 3'd1);
    kind   = KIND_LEFT;
    value  = '0;
    if (batch.nz_x && idx == '0) begin
      kind  = KIND_REL_X;
      value = batch.dx;
    end else if (idx < {1'b0, offset}) begin
      kind  = KIND_REL_Y;
      value = batch.dy;
    end else begin
      case (batch.act)
        ACT_CLICK, ACT_DOUBLE: begin
          kind  = KIND_LEFT;
          value = k[0] ? 18'sd0 : 18'sd1;
        end
        ACT_WHEEL_DN: begin
          kind  = KIND_WHEEL;
          value = -18'sd1;
        end
        ACT_WHEEL_UP: begin
          kind  = KIND_WHEEL;
          value = 18'sd1;
        end
        ACT_PRESS: begin
          kind  = KIND_LEFT;
          value = 18'sd1;
        end
        ACT_RELEASE: begin
          kind  = KIND_LEFT;
          value = 18'sd0;
        end
        ACT_RIGHT: begin
          kind  = KIND_RIGHT;
          value = k[0] ? 18'sd0 : 18'sd1;
        end
        default: begin
          kind  = KIND_LEFT;
          value = 18'sd0;
        end
      endcase
    end
  end

endmodule

/* src/pep_checker.sv */
// Port-level checks of the pointer event generator, bound to the top level.
module pep_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [2:0]                         event_kind,
  input logic signed [pep_pkg::DeltaW-1:0]  event_value,
  input logic                               last_event
);
  import pep_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_kind) &&
      $stable(event_value) && $stable(last_event))
    else $error("stalled event changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not idle after reset");

  a_wheel_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == KIND_WHEEL |-> event_value == 18'sd1 ||
      event_value == -18'sd1)
    else $error("wheel step not unit");

  a_button_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == KIND_LEFT || event_kind == KIND_RIGHT) |->
      event_value == 18'sd0 || event_value == 18'sd1)
    else $error("button level out of range");

  a_delta_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == KIND_REL_X || event_kind == KIND_REL_Y) |->
      event_value != 18'sd0)
    else $error("zero delta emitted");

endmodule

bind pointer_event_generator pep_checker u_pep_checker (.*);
